// ===== sv/assert_macros.svh =====
// Assertion macros shared by the link impairment delay queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LIDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lidq: property violated");
`define LIDQ_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lidq: forbidden condition seen");
`else
`define LIDQ_ASSERT(lbl, prop)
`define LIDQ_NEVER(lbl, cond)
`endif
`endif

// ===== sv/lidq_pkg.sv =====
// Types and constants of the link impairment delay queue.
`default_nettype none
package lidq_pkg;

  localparam logic [1:0] KIND_PASS     = 2'd0;
  localparam logic [1:0] KIND_DROP     = 2'd1;
  localparam logic [1:0] KIND_RELEASE  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  localparam logic [2:0] CFG_ENABLE       = 3'd0;
  localparam logic [2:0] CFG_BASE_DELAY   = 3'd1;
  localparam logic [2:0] CFG_DROP_PROB    = 3'd2;
  localparam logic [2:0] CFG_BURST_PROB   = 3'd3;
  localparam logic [2:0] CFG_BURST_LEN    = 3'd4;
  localparam logic [2:0] CFG_REORDER_PROB = 3'd5;
  localparam logic [2:0] CFG_REORDER_MAX  = 3'd6;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_STORE,
    OP_TICK
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [1:0]  kind;
    logic [31:0] stamp;   // release time for a store, current time for a tick
  } cmd_t;

  typedef struct packed {
    logic        enable_impairment;
    logic [15:0] base_delay_ms;
    logic [15:0] drop_probability;
    logic [15:0] burst_start_probability;
    logic [7:0]  burst_length;
    logic [15:0] reorder_probability;
    logic [15:0] extra_delay_max;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_SHIFT
  } bk_state_t;

endpackage
`default_nettype wire

// ===== sv/link_impairment_delay_queue.sv =====
// Top level of the link impairment delay queue: config registers and channel wiring.
//
// Use: items enter on the in_ stream. in_tuser selects packet arrival (0) or relay
// tick (1); in_tdata holds the time stamp, payload and four random draws. Results
// leave on the out_ stream with the payload in out_tdata, the result kind in
// out_tuser and out_tlast on the final result an item causes.
// A pass, drop or overflow result passes the front hold register, the command queue
// and the output register; a stored packet passes the hold register and the queue.
// Throughput: one arrival every cycle while the back section is idle and results are taken.
// A tick scans the store once per released packet, reading one entry per cycle,
// and compacts the store behind each one; a last scan finds nothing due and ends the tick.
// A two-entry command queue lets the front keep taking items during that work.
// Reset: config registers return to their defaults, the store is emptied and
// any burst in progress ends.
// Stall: a held result stays on out_ until taken; the back section then waits
// and the command queue fills, after which in_tready drops.
`default_nettype none
`include "assert_macros.svh"
module link_impairment_delay_queue #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 64,
  localparam int InDataW     = ((96 + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OutDataW    = ((PAYLOAD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // now_ms[31:0], payload, rand_burst, rand_drop, rand_reorder, rand_extra
  input  logic [InDataW-1:0]  in_tdata,
  // mode
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_payload
  output logic [OutDataW-1:0] out_tdata,
  // out_kind
  output logic [1:0]          out_tuser,
  output logic                out_tlast,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  localparam int FifoW = $bits(lidq_pkg::cmd_t) + PAYLOAD_BITS;

  lidq_pkg::cfg_t          cfg_r;
  logic                    fifo_push;
  logic                    fifo_full;
  logic                    fifo_pop;
  logic                    fifo_empty;
  lidq_pkg::cmd_t          push_cmd;
  logic [PAYLOAD_BITS-1:0] push_payload;
  logic [FifoW-1:0]        pop_data;
  lidq_pkg::cmd_t          pop_cmd;
  logic [PAYLOAD_BITS-1:0] pop_payload;
  logic [PAYLOAD_BITS-1:0] out_payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_impairment       <= 1'b1;
      cfg_r.base_delay_ms           <= 16'd0;
      cfg_r.drop_probability        <= 16'd0;
      cfg_r.burst_start_probability <= 16'd0;
      cfg_r.burst_length            <= 8'd3;
      cfg_r.reorder_probability     <= 16'd0;
      cfg_r.extra_delay_max         <= 16'd50;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        lidq_pkg::CFG_ENABLE:       cfg_r.enable_impairment       <= cfg_wdata[0];
        lidq_pkg::CFG_BASE_DELAY:   cfg_r.base_delay_ms           <= cfg_wdata;
        lidq_pkg::CFG_DROP_PROB:    cfg_r.drop_probability        <= cfg_wdata;
        lidq_pkg::CFG_BURST_PROB:   cfg_r.burst_start_probability <= cfg_wdata;
        lidq_pkg::CFG_BURST_LEN:    cfg_r.burst_length            <= cfg_wdata[7:0];
        lidq_pkg::CFG_REORDER_PROB: cfg_r.reorder_probability     <= cfg_wdata;
        lidq_pkg::CFG_REORDER_MAX:  cfg_r.extra_delay_max         <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lidq_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_mode         (in_tuser),
    .in_now          (in_tdata[31:0]),
    .in_payload      (in_tdata[32 +: PAYLOAD_BITS]),
    .in_rand_burst   (in_tdata[32 + PAYLOAD_BITS +: 16]),
    .in_rand_drop    (in_tdata[48 + PAYLOAD_BITS +: 16]),
    .in_rand_reorder (in_tdata[64 + PAYLOAD_BITS +: 16]),
    .in_rand_extra   (in_tdata[80 + PAYLOAD_BITS +: 16]),
    .push            (fifo_push),
    .push_cmd        (push_cmd),
    .push_payload    (push_payload),
    .fifo_full       (fifo_full)
  );

  lidq_fifo #(
    .WIDTH (FifoW)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data ({push_payload, push_cmd}),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  assign pop_cmd     = pop_data[$bits(lidq_pkg::cmd_t)-1:0];
  assign pop_payload = pop_data[$bits(lidq_pkg::cmd_t) +: PAYLOAD_BITS];

  lidq_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_empty   (fifo_empty),
    .fifo_cmd     (pop_cmd),
    .fifo_payload (pop_payload),
    .fifo_pop     (fifo_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_payload  (out_payload),
    .out_kind     (out_tuser),
    .out_last     (out_tlast)
  );

  assign out_tdata = OutDataW'(out_payload);

  `LIDQ_ASSERT(a_single_result_last, out_tvalid && (out_tuser != lidq_pkg::KIND_RELEASE) |-> out_tlast)
  `LIDQ_ASSERT(a_drop_zero_payload, out_tvalid && (out_tuser == lidq_pkg::KIND_DROP || out_tuser == lidq_pkg::KIND_OVERFLOW) |-> out_tdata == '0)
  `LIDQ_NEVER(a_no_push_when_full, fifo_push && fifo_full)
  `LIDQ_NEVER(a_no_pop_when_empty, fifo_pop && fifo_empty)

endmodule
`default_nettype wire

// ===== sv/lidq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lidq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/lidq_fifo.sv =====
// Two-entry command queue between the front and back sections.
`default_nettype none
module lidq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/lidq_front.sv =====
// Front section: accepts items, runs loss decisions, forms queue commands.
`default_nettype none
module lidq_front #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lidq_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [31:0]             in_now,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [15:0]             in_rand_burst,
  input  logic [15:0]             in_rand_drop,
  input  logic [15:0]             in_rand_reorder,
  input  logic [15:0]             in_rand_extra,
  output logic                    push,
  output lidq_pkg::cmd_t          push_cmd,
  output logic [PAYLOAD_BITS-1:0] push_payload,
  input  logic                    fifo_full
);

  logic                    hold_valid_r;
  logic [7:0]              burst_rem_r;
  logic [7:0]              burst_rem_nxt;
  lidq_pkg::cmd_op_t       hold_op_r;
  lidq_pkg::cmd_op_t       hold_op_nxt;
  logic [1:0]              hold_kind_r;
  logic [1:0]              hold_kind_nxt;
  logic [31:0]             hold_now_r;
  logic [15:0]             hold_extra_r;
  logic [15:0]             hold_extra_nxt;
  logic [PAYLOAD_BITS-1:0] hold_pay_r;
  logic [PAYLOAD_BITS-1:0] hold_pay_nxt;
  logic [31:0]             product;
  logic [31:0]             rel_stamp;
  logic                    accept;

  assign push     = hold_valid_r && !fifo_full;
  assign in_ready = !hold_valid_r || !fifo_full;
  assign accept   = in_valid && in_ready;

  assign product = 32'(in_rand_extra) * 32'(cfg.extra_delay_max);

  always_comb begin
    hold_op_nxt    = lidq_pkg::OP_STORE;
    hold_kind_nxt  = lidq_pkg::KIND_PASS;
    hold_pay_nxt   = in_payload;
    burst_rem_nxt  = burst_rem_r;
    hold_extra_nxt = (in_rand_reorder < cfg.reorder_probability) ? product[31:16] : 16'd0;
    if (in_mode) begin
      hold_op_nxt = lidq_pkg::OP_TICK;
    end else if (!cfg.enable_impairment) begin
      hold_op_nxt = lidq_pkg::OP_EMIT;
    end else if (burst_rem_r != 8'd0) begin
      hold_op_nxt   = lidq_pkg::OP_EMIT;
      hold_kind_nxt = lidq_pkg::KIND_DROP;
      hold_pay_nxt  = '0;
      burst_rem_nxt = burst_rem_r - 8'd1;
    end else if (in_rand_burst < cfg.burst_start_probability) begin
      hold_op_nxt   = lidq_pkg::OP_EMIT;
      hold_kind_nxt = lidq_pkg::KIND_DROP;
      hold_pay_nxt  = '0;
      burst_rem_nxt = (cfg.burst_length != 8'd0) ? cfg.burst_length - 8'd1 : 8'd0;
    end else if (in_rand_drop < cfg.drop_probability) begin
      hold_op_nxt   = lidq_pkg::OP_EMIT;
      hold_kind_nxt = lidq_pkg::KIND_DROP;
      hold_pay_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      burst_rem_r  <= 8'd0;
    end else begin
      if (accept) begin
        hold_valid_r <= 1'b1;
        burst_rem_r  <= burst_rem_nxt;
      end else if (push) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op_r    <= hold_op_nxt;
      hold_kind_r  <= hold_kind_nxt;
      hold_now_r   <= in_now;
      hold_extra_r <= hold_extra_nxt;
      hold_pay_r   <= hold_pay_nxt;
    end
  end

  assign rel_stamp = hold_now_r + 32'(cfg.base_delay_ms) + 32'(hold_extra_r);

  always_comb begin
    push_cmd.op    = hold_op_r;
    push_cmd.kind  = hold_kind_r;
    push_cmd.stamp = (hold_op_r == lidq_pkg::OP_STORE) ? rel_stamp : hold_now_r;
    push_payload   = hold_pay_r;
  end

endmodule
`default_nettype wire

// ===== sv/lidq_back.sv =====
// Back section: holds the delay store, emits results and drains due packets.
`default_nettype none
module lidq_back #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fifo_empty,
  input  lidq_pkg::cmd_t          fifo_cmd,
  input  logic [PAYLOAD_BITS-1:0] fifo_payload,
  output logic                    fifo_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [1:0]              out_kind,
  output logic                    out_last
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_W = 32 + PAYLOAD_BITS;

  lidq_pkg::bk_state_t     state_r;
  lidq_pkg::bk_state_t     state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        iss_r;
  logic [CNT_W-1:0]        iss_nxt;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    dvalid_r;
  logic [AW-1:0]           didx_r;
  logic [31:0]             now_r;
  logic                    found_r;
  logic [AW-1:0]           best_idx_r;
  logic [31:0]             best_key_r;
  logic [PAYLOAD_BITS-1:0] best_pay_r;
  logic                    pend_valid_r;
  logic [PAYLOAD_BITS-1:0] pend_pay_r;
  logic                    out_valid_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [1:0]              out_kind_r;
  logic                    out_last_r;

  logic                    can_emit;
  logic                    emit;
  logic [PAYLOAD_BITS-1:0] emit_pay;
  logic [1:0]              emit_kind;
  logic                    emit_last;
  logic                    found_clr;
  logic                    now_load;
  logic                    pend_load;
  logic                    pend_clr;
  logic                    take;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [RAM_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [RAM_W-1:0]        ram_rdata;
  logic [31:0]             rd_time;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [31:0]             diff;
  logic [31:0]             key;
  logic                    due;

  lidq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign can_emit = !out_valid_r || out_ready;
  assign cnt_m1   = count_r - CNT_W'(1);
  assign rd_time  = ram_rdata[31:0];
  assign rd_pay   = ram_rdata[32 +: PAYLOAD_BITS];
  assign diff     = rd_time - now_r;
  assign due      = (diff == 32'd0) || diff[31];
  assign key      = diff ^ 32'h8000_0000;
  assign take     = (state_r == lidq_pkg::BK_SCAN) && dvalid_r && due &&
                    (!found_r || (key < best_key_r));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    iss_nxt   = iss_r;
    fifo_pop  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = {fifo_payload, fifo_cmd.stamp};
    ram_re    = 1'b0;
    ram_raddr = iss_r[AW-1:0];
    emit      = 1'b0;
    emit_pay  = '0;
    emit_kind = lidq_pkg::KIND_PASS;
    emit_last = 1'b1;
    found_clr = 1'b0;
    now_load  = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    case (state_r)
      lidq_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          case (fifo_cmd.op)
            lidq_pkg::OP_EMIT: begin
              if (can_emit) begin
                emit      = 1'b1;
                emit_pay  = fifo_payload;
                emit_kind = fifo_cmd.kind;
                fifo_pop  = 1'b1;
              end
            end
            lidq_pkg::OP_STORE: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                if (can_emit) begin
                  emit      = 1'b1;
                  emit_kind = lidq_pkg::KIND_OVERFLOW;
                  fifo_pop  = 1'b1;
                end
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                fifo_pop  = 1'b1;
              end
            end
            lidq_pkg::OP_TICK: begin
              fifo_pop = 1'b1;
              if (count_r != '0) begin
                state_nxt = lidq_pkg::BK_SCAN;
                iss_nxt   = '0;
                found_clr = 1'b1;
                now_load  = 1'b1;
              end
            end
            default: begin
              fifo_pop = 1'b1;
            end
          endcase
        end
      end
      lidq_pkg::BK_SCAN: begin
        if (count_r == '0) begin
          state_nxt = lidq_pkg::BK_DECIDE;
        end else begin
          if (iss_r < count_r) begin
            ram_re  = 1'b1;
            iss_nxt = iss_r + CNT_W'(1);
          end
          if (dvalid_r && (didx_r == cnt_m1[AW-1:0])) begin
            state_nxt = lidq_pkg::BK_DECIDE;
          end
        end
      end
      lidq_pkg::BK_DECIDE: begin
        if (!pend_valid_r || can_emit) begin
          if (pend_valid_r) begin
            emit      = 1'b1;
            emit_pay  = pend_pay_r;
            emit_kind = lidq_pkg::KIND_RELEASE;
            emit_last = !found_r;
          end
          if (found_r) begin
            pend_load = 1'b1;
            count_nxt = cnt_m1;
            if (best_idx_r == cnt_m1[AW-1:0]) begin
              state_nxt = lidq_pkg::BK_SCAN;
              iss_nxt   = '0;
              found_clr = 1'b1;
            end else begin
              state_nxt = lidq_pkg::BK_SHIFT;
              iss_nxt   = CNT_W'(best_idx_r) + CNT_W'(1);
            end
          end else begin
            pend_clr  = 1'b1;
            state_nxt = lidq_pkg::BK_IDLE;
          end
        end
      end
      lidq_pkg::BK_SHIFT: begin
        // count_r already excludes the released entry; copy entries down by one
        if (iss_r <= count_r) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (dvalid_r) begin
          ram_we    = 1'b1;
          ram_waddr = didx_r - AW'(1);
          ram_wdata = ram_rdata;
          if (didx_r == count_r[AW-1:0]) begin
            state_nxt = lidq_pkg::BK_SCAN;
            iss_nxt   = '0;
            found_clr = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lidq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lidq_pkg::BK_IDLE;
      count_r      <= '0;
      iss_r        <= '0;
      dvalid_r     <= 1'b0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      iss_r    <= iss_nxt;
      dvalid_r <= ram_re;
      if (found_clr) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      didx_r <= ram_raddr;
    end
    if (now_load) begin
      now_r <= fifo_cmd.stamp;
    end
    if (take) begin
      best_idx_r <= didx_r;
      best_key_r <= key;
      best_pay_r <= rd_pay;
    end
    if (pend_load) begin
      pend_pay_r <= best_pay_r;
    end
    if (emit) begin
      out_pay_r  <= emit_pay;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_pay_r;
  assign out_kind    = out_kind_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire
